/* design/rbd_pkg.sv */
// Shared constants, register codes and control types of the 2x2 box downsampler.
package rbd_pkg;

    // Default line store sizing and fixed field widths.
    localparam int DEF_MAX_WIDTH = 8192;
    localparam int HEIGHT_LIMIT  = 8192;
    localparam int DIM_W         = 14;
    localparam int ROW_W         = 13;
    localparam int CMP_W         = DIM_W + 1;
    localparam int CH_W          = 8;
    localparam int PAIR_W        = 10;
    localparam int CHANNELS      = 4;
    localparam int TAP_SHIFT     = 2;
    localparam int LINE_W        = CHANNELS * PAIR_W;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;

    // Per-pixel decisions taken from the position counters.
    typedef struct packed {
        logic capture;   // even column: keep the pixel for the pair
        logic line_wr;   // even row: park the pair sum in the line store
        logic emit;      // this pixel completes an output block
        logic last;      // the completed block is the level's final pixel
        logic w_one;     // width of one: the pixel pairs with itself
        logic h_one;     // height of one: the pair sum pairs with itself
    } t_step;

    // Control seen by each channel lane.
    typedef struct packed {
        logic accept;
        logic capture;
        logic w_one;
        logic s1_h_one;
    } t_lane_ctl;

endpackage

/* design/rbd_ifs.sv */
// Stream interfaces of the downsampler: pixel in, pixel out and configuration write.
interface rbd_pix_in_if;
    logic                      valid;
    logic                      ready;
    logic [rbd_pkg::CH_W-1:0]  in_red;
    logic [rbd_pkg::CH_W-1:0]  in_green;
    logic [rbd_pkg::CH_W-1:0]  in_blue;
    logic [rbd_pkg::CH_W-1:0]  in_alpha;

    modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface rbd_pix_out_if;
    logic                      valid;
    logic                      ready;
    logic [rbd_pkg::CH_W-1:0]  out_red;
    logic [rbd_pkg::CH_W-1:0]  out_green;
    logic [rbd_pkg::CH_W-1:0]  out_blue;
    logic [rbd_pkg::CH_W-1:0]  out_alpha;
    logic                      out_last;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, out_last,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_alpha, out_last,
                    output ready);
endinterface

interface rbd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [rbd_pkg::CFG_IDX_W-1:0]  index;
    logic [rbd_pkg::DIM_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* design/rbd_ctrl.sv */
// Configuration registers, position counters and per-pixel step decisions.
module rbd_ctrl #(
    parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    rbd_cfg_if.sink             i_cfg,
    input  logic                i_accept,
    output rbd_pkg::t_step      o_step,
    output logic [(MAX_WIDTH/2 > 1 ? $clog2(MAX_WIDTH/2) : 1)-1:0] o_idx
);
    import rbd_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic            r_w_one, r_h_one;
    logic [CW-1:0]   r_w_m1, r_dw_m1;
    logic [ROW_W-1:0] r_h_m1, r_dh_m1;
    logic [CW-1:0]   r_col;
    logic [ROW_W-1:0] r_row;

    logic [WW-1:0]   w_eff;
    logic [DIM_W-1:0] h_eff;
    logic            cfg_fire, wr_width, wr_height;
    logic [CW-1:0]   ox;
    logic [ROW_W-1:0] oy;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid;

    // Register decode; an index beyond the list writes nothing.
    always_comb begin
        wr_width  = 1'b0;
        wr_height = 1'b0;
        unique case (i_cfg.index)
            REG_SOURCE_WIDTH:  wr_width  = cfg_fire;
            REG_SOURCE_HEIGHT: wr_height = cfg_fire;
            default: ;
        endcase
    end

    // Clamp a written dimension: zero acts as one, oversize acts as the limit.
    always_comb begin
        if (i_cfg.data == '0) begin
            w_eff = WW'(1);
        end else if ({1'b0, i_cfg.data} > CMP_W'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(i_cfg.data);
        end
        if (i_cfg.data == '0) begin
            h_eff = DIM_W'(1);
        end else if (i_cfg.data > DIM_W'(HEIGHT_LIMIT)) begin
            h_eff = DIM_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = i_cfg.data;
        end
    end

    // Derived dimension registers, held ready for the counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_one <= 1'b1;
            r_w_m1  <= '0;
            r_dw_m1 <= '0;
            r_h_one <= 1'b1;
            r_h_m1  <= '0;
            r_dh_m1 <= '0;
        end else begin
            if (wr_width) begin
                r_w_one <= (w_eff == WW'(1));
                r_w_m1  <= CW'(w_eff - WW'(1));
                r_dw_m1 <= (w_eff == WW'(1)) ? '0 : CW'((w_eff >> 1) - WW'(1));
            end
            if (wr_height) begin
                r_h_one <= (h_eff == DIM_W'(1));
                r_h_m1  <= ROW_W'(h_eff - DIM_W'(1));
                r_dh_m1 <= (h_eff == DIM_W'(1)) ? '0 : ROW_W'((h_eff >> 1) - DIM_W'(1));
            end
        end
    end

    // Raster position of the next pixel; wraps at row and image end and restarts on a dimension write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (wr_width || wr_height) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            if (r_col == r_w_m1) begin
                r_col <= '0;
                r_row <= (r_row == r_h_m1) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // Decisions for the pixel at the current position. Odd columns and rows
    // are always inside the reduced area, so parity alone selects the pairs.
    assign ox = r_col >> 1;
    assign oy = r_row >> 1;
    assign o_idx = ox[IW-1:0];

    always_comb begin
        o_step.capture = !r_w_one && !r_col[0];
        o_step.w_one   = r_w_one;
        o_step.h_one   = r_h_one;
        o_step.line_wr = (r_w_one || r_col[0]) && !r_h_one && !r_row[0];
        o_step.emit    = (r_w_one || r_col[0]) && (r_h_one || r_row[0]);
        o_step.last    = (ox == r_dw_m1) && (oy == r_dh_m1);
    end

endmodule

/* design/rbd_lane.sv */
// One colour channel: horizontal pair sum, then the vertical sum and average.
module rbd_lane (
    input  logic                        i_clk,
    input  rbd_pkg::t_lane_ctl          i_ctl,
    input  logic [rbd_pkg::CH_W-1:0]    i_px,
    input  logic [rbd_pkg::PAIR_W-1:0]  i_line,
    output logic [rbd_pkg::PAIR_W-1:0]  o_pair,
    output logic [rbd_pkg::CH_W-1:0]    o_avg
);
    import rbd_pkg::*;

    logic [CH_W-1:0]   r_held;
    logic [PAIR_W-1:0] r_pair;
    logic [PAIR_W:0]   sum;

    // Pair of the held even pixel with this one, or the pixel doubled.
    assign o_pair = i_ctl.w_one ? {1'b0, i_px, 1'b0}
                                : PAIR_W'(r_held) + PAIR_W'(i_px);

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_ctl.capture) begin
            r_held <= i_px;
        end
        if (i_ctl.accept) begin
            r_pair <= o_pair;
        end
    end

    // Block sum from the stored pair of the row above, or the pair doubled.
    assign sum   = i_ctl.s1_h_one ? {r_pair, 1'b0}
                                  : (PAIR_W + 1)'(i_line) + (PAIR_W + 1)'(r_pair);
    assign o_avg = sum[PAIR_W-1:TAP_SHIFT];

endmodule

/* design/rbd_line.sv */
// Line store for the pair sums of an even row, one write and one registered read.
module rbd_line #(
    parameter int DEPTH = rbd_pkg::DEF_MAX_WIDTH / 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        i_clk,
    input  logic                        i_wr,
    input  logic                        i_rd,
    input  logic [AW-1:0]               i_addr,
    input  logic [rbd_pkg::LINE_W-1:0]  i_wdata,
    output logic [rbd_pkg::LINE_W-1:0]  o_rdata
);
    import rbd_pkg::*;

    logic [LINE_W-1:0] r_mem [DEPTH];
    logic [LINE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/rgba_box_downsample_2x2.sv */
// Top level of the streaming 2x2 box-filter RGBA8 downsampler.
//
// Source pixels enter in raster order, one beat per clock unless held off,
// and every odd column of an odd row (any column or row of a dimension of
// one) completes a 2x2 block whose per-channel truncated average leaves on
// the output channel, with out_last on the level's final pixel. The rate is
// one pixel per clock while the output does not stall, set by the single-port
// line store (MAX_WIDTH/2 entries of four 10-bit pair sums) that takes one
// write or read per pixel. A result passes two registers: the pair sum and
// line store read, then the vertical sum into the output register. The
// output register lets a new pixel in while a result waits. The line store
// needs no clearing pass after reset. Writing either dimension register
// restarts the image at its first pixel; write only while the block is idle.
module rgba_box_downsample_2x2 #(
    parameter int MAX_WIDTH = rbd_pkg::DEF_MAX_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rbd_cfg_if.sink         i_cfg,
    rbd_pix_in_if.sink      i_pix,
    rbd_pix_out_if.source   o_pix
);
    import rbd_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    t_step             step;
    logic [IW-1:0]     idx;
    logic              accept, advance, s1_take;
    logic [CH_W-1:0]   px   [CHANNELS];
    logic [CH_W-1:0]   avg  [CHANNELS];
    logic [LINE_W-1:0] wdata, rdata;
    t_lane_ctl         lane_ctl;

    logic              r_s1_valid, r_s1_emit, r_s1_last, r_s1_h_one;
    logic              r_out_valid, r_out_last;
    logic [CH_W-1:0]   r_out [CHANNELS];

    // Handshake: the first stage moves when the output register is free or
    // being emptied.
    assign advance     = !r_out_valid || o_pix.ready;
    assign s1_take     = r_s1_valid && advance;
    assign i_pix.ready = !r_s1_valid || advance;
    assign accept      = i_pix.valid && i_pix.ready;

    rbd_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_accept (accept),
        .o_step   (step),
        .o_idx    (idx)
    );

    assign px[0] = i_pix.in_red;
    assign px[1] = i_pix.in_green;
    assign px[2] = i_pix.in_blue;
    assign px[3] = i_pix.in_alpha;

    always_comb begin
        lane_ctl.accept   = accept;
        lane_ctl.capture  = step.capture;
        lane_ctl.w_one    = step.w_one;
        lane_ctl.s1_h_one = r_s1_h_one;
    end

    // One lane per colour channel, sharing the line store word.
    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        rbd_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_px   (px[c]),
            .i_line (rdata[c*PAIR_W +: PAIR_W]),
            .o_pair (wdata[c*PAIR_W +: PAIR_W]),
            .o_avg  (avg[c])
        );
    end

    rbd_line #(.DEPTH(LINE_DEPTH), .AW(IW)) u_line (
        .i_clk   (i_clk),
        .i_wr    (accept && step.line_wr),
        .i_rd    (accept && step.emit && !step.h_one),
        .i_addr  (idx),
        .i_wdata (wdata),
        .o_rdata (rdata)
    );

    // First stage: the beat's decisions wait beside the line store read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_emit  <= step.emit;
            r_s1_last  <= step.last;
            r_s1_h_one <= step.h_one;
        end
    end

    // Merge the lane averages into the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_take && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_take && r_s1_emit) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_out[c] <= avg[c];
            end
            r_out_last <= r_s1_last;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_red   = r_out[0];
    assign o_pix.out_green = r_out[1];
    assign o_pix.out_blue  = r_out[2];
    assign o_pix.out_alpha = r_out[3];
    assign o_pix.out_last  = r_out_last;

endmodule
